FILE: rtl/core/business_day_date_advance_macros.svh
// Assertion macros shared by the business-day date advance RTL.
`ifndef BUSINESS_DAY_DATE_ADVANCE_MACROS_SVH
`define BUSINESS_DAY_DATE_ADVANCE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define BDDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bdda assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDDA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bdda assertion failed");

`else

`define BDDA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BDDA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/bdda_pkg.sv
// Package with the types, constants and calendar functions of the business-day date advance.
`timescale 1ns / 1ps

package bdda_pkg;

	localparam int YEAR_W = 15;
	localparam int YMOD_W = 9;
	localparam int SUM_W  = 15;
	localparam int PROD_W = 25;

	localparam logic [6:0]        MASK_RESET = 7'd96;
	localparam logic [12:0]       RECIP25    = 13'd5243;
	localparam logic [YEAR_W-1:0] ERA_SHIFT  = 15'd400;
	localparam logic [YMOD_W-1:0] YMOD_LAST  = 9'd399;

	typedef struct packed {
		logic [13:0] start_year;
		logic [3:0]  start_month;
		logic [4:0]  start_day;
		logic [15:0] business_days;
	} bdda_in_t;

	typedef struct packed {
		logic [13:0] return_year;
		logic [3:0]  return_month;
		logic [4:0]  return_day;
		logic [2:0]  return_weekday;
		logic        bad_date;
	} bdda_out_t;

	// Calendar position carried through the walk; ymod is the year modulo 400.
	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [YMOD_W-1:0] ymod;
		logic [2:0]        wd;
	} bdda_date_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_YMUL,
		S_YMOD,
		S_CHECK,
		S_SUM,
		S_FOLD,
		S_WALK
	} bdda_state_t;

	function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
		logic cent;
		cent = (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
		return ((ymod[1:0] == 2'd0) && !cent) || (ymod == 9'd0);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		unique case (month)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// Month term of the March-based weekday formula, floor(31 * shifted month / 12).
	function automatic logic [4:0] month_offset(input logic [3:0] month);
		logic [4:0] off;
		unique case (month)
			4'd1:    off = 5'd28;
			4'd2:    off = 5'd31;
			4'd3:    off = 5'd2;
			4'd4:    off = 5'd5;
			4'd5:    off = 5'd7;
			4'd6:    off = 5'd10;
			4'd7:    off = 5'd12;
			4'd8:    off = 5'd15;
			4'd9:    off = 5'd18;
			4'd10:   off = 5'd20;
			4'd11:   off = 5'd23;
			4'd12:   off = 5'd25;
			default: off = 5'd0;
		endcase
		return off;
	endfunction

endpackage

FILE: rtl/core/bdda_day_step.sv
// One-day calendar advance: day, month, year, year modulo 400 and weekday.
`timescale 1ns / 1ps

module bdda_day_step import bdda_pkg::*; (
	input  bdda_date_t cur,
	output bdda_date_t nxt
);

	logic [4:0] mlen;

	assign mlen = month_len(cur.month, is_leap(cur.ymod));

	always_comb begin
		nxt = cur;
		nxt.wd = (cur.wd == 3'd6) ? 3'd0 : cur.wd + 3'd1;
		if (cur.day >= mlen) begin
			nxt.day = 5'd1;
			if (cur.month == 4'd12) begin
				nxt.month = 4'd1;
				nxt.year  = cur.year + 15'd1;
				nxt.ymod  = (cur.ymod == YMOD_LAST) ? 9'd0 : cur.ymod + 9'd1;
			end else begin
				nxt.month = cur.month + 4'd1;
			end
		end else begin
			nxt.day = cur.day + 5'd1;
		end
	end

endmodule

FILE: rtl/core/business_day_date_advance.sv
// Top level of the business-day date advance: sequencer, shared multiplier and day walker.
`timescale 1ns / 1ps
`include "business_day_date_advance_macros.svh"

// A request is taken when start is high and busy is low; busy then stays high until the
// result is ready. One request first runs its setup (year modulo 400 and the weekday,
// both through one shared 13x13 reciprocal multiplier, then modulo-7 folding steps and
// a step that takes the weekday), then walks the calendar one day at a time and ends
// with a closing step. The walk covers about 7/(business days per week) days per
// business day requested. The result appears for one cycle with done high and must be
// taken in that cycle; busy falls in the same cycle, so the next request may follow at
// once. An invalid start date ends the request after the check.
module business_day_date_advance import bdda_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  bdda_in_t  req,
	output logic      done,
	output bdda_out_t rsp,
	input  logic      cfg_we,
	input  logic [6:0] cfg_wdata
);

	bdda_state_t state_q, state_d;
	logic        finish;
	logic        done_q;
	logic [6:0]  mask_q;
	bdda_out_t   rsp_q;

	bdda_date_t        date_q, date_nxt;
	logic [15:0]       cnt_q;
	logic [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0]  sum_q;

	logic              jan_feb;
	logic [YEAR_W-1:0] yy;
	logic [12:0]       mul_a;
	logic [25:0]       mul_full;
	logic [YEAR_W-1:0] q400_x;
	logic [YEAR_W-1:0] ymod_full;
	logic [SUM_W-1:0]  sum_calc;
	logic [SUM_W-1:0]  fold_calc;
	logic              date_ok;
	logic              all_off;
	logic              biz;
	logic              walk_end;

	// Shifted-month year: January and February count as months of the year before.
	assign jan_feb = (date_q.month == 4'd1) || (date_q.month == 4'd2);
	assign yy      = date_q.year + ERA_SHIFT - YEAR_W'(jan_feb);

	// The one multiplier: floor(x / 25) = (x * 5243) >> 17 for the range used here.
	assign mul_a    = (state_q == S_YMUL) ? date_q.year[14:2] : yy[14:2];
	assign mul_full = mul_a * RECIP25;

	assign q400_x    = YEAR_W'(prod_q[24:19]) * YEAR_W'(400);
	assign ymod_full = date_q.year - q400_x;

	assign sum_calc = SUM_W'(date_q.day) + yy + SUM_W'(yy[14:2]) - SUM_W'(prod_q[24:17])
		+ SUM_W'(prod_q[24:19]) + SUM_W'(month_offset(date_q.month));

	// Eight is one modulo seven, so adding the octal digits keeps the remainder.
	assign fold_calc = SUM_W'(sum_q[14:3]) + SUM_W'(sum_q[2:0]);

	assign date_ok = (date_q.month >= 4'd1) && (date_q.month <= 4'd12) && (date_q.day != 5'd0)
		&& (date_q.day <= month_len(date_q.month, is_leap(date_q.ymod)));

	assign all_off  = (mask_q == 7'h7F);
	assign biz      = !mask_q[date_q.wd];
	assign walk_end = (cnt_q == 16'd0) || all_off;

	bdda_day_step u_step (
		.cur (date_q),
		.nxt (date_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			mask_q  <= MASK_RESET;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		finish  = 1'b0;
		unique case (state_q)
			S_IDLE:  if (start) state_d = S_YMUL;
			S_YMUL:  state_d = S_YMOD;
			S_YMOD:  state_d = S_CHECK;
			S_CHECK: begin
				if (date_ok) begin
					state_d = S_SUM;
				end else begin
					state_d = S_IDLE;
					finish  = 1'b1;
				end
			end
			S_SUM:   state_d = S_FOLD;
			S_FOLD:  if (sum_q < SUM_W'(8)) state_d = S_WALK;
			S_WALK: begin
				if (walk_end) begin
					state_d = S_IDLE;
					finish  = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					date_q.year  <= {1'b0, req.start_year};
					date_q.month <= req.start_month;
					date_q.day   <= req.start_day;
					cnt_q        <= req.business_days;
				end
			end
			S_YMUL:  prod_q <= mul_full[PROD_W-1:0];
			S_YMOD:  date_q.ymod <= ymod_full[YMOD_W-1:0];
			S_CHECK: prod_q <= mul_full[PROD_W-1:0];
			S_SUM:   sum_q <= sum_calc;
			S_FOLD: begin
				if (sum_q >= SUM_W'(8)) begin
					sum_q <= fold_calc;
				end else begin
					date_q.wd <= (sum_q[2:0] == 3'd7) ? 3'd0 : sum_q[2:0];
				end
			end
			S_WALK: begin
				if (!walk_end) begin
					cnt_q  <= cnt_q - 16'(biz);
					date_q <= date_nxt;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q.return_year  <= date_q.year[13:0];
			rsp_q.return_month <= date_q.month;
			rsp_q.return_day   <= date_q.day;
			if (state_q == S_CHECK) begin
				rsp_q.return_weekday <= 3'd0;
				rsp_q.bad_date       <= 1'b1;
			end else begin
				rsp_q.return_weekday <= date_q.wd;
				rsp_q.bad_date       <= 1'b0;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	`BDDA_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy && !done)
	`BDDA_ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy) && !busy)
	`BDDA_ASSERT_IMP(a_bad_weekday, clk, arst_n, done && rsp.bad_date, rsp.return_weekday == 3'd0)
	`BDDA_ASSERT_IMP(a_good_date, clk, arst_n, done && !rsp.bad_date, (rsp.return_day != 5'd0) && (rsp.return_month >= 4'd1) && (rsp.return_month <= 4'd12) && (rsp.return_weekday != 3'd7))

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the business-day date advance block.
`timescale 1ns / 1ps

module tb;
	import bdda_pkg::*;

	localparam int         LIMIT      = 20_000_000;
	localparam int         TAIL       = 40;
	localparam logic [6:0] ALL_OFF    = 7'h7F;
	localparam logic [6:0] NONE_OFF   = 7'h00;
	localparam logic [6:0] SAT_SUN    = 7'h41;
	localparam logic [6:0] SAT_ONLY   = 7'h3F;
	localparam logic [6:0] SUN_ONLY   = 7'h7E;
	localparam logic [6:0] FRI_SAT    = 7'h60;

	typedef enum logic [1:0] {
		OP_ITEM,
		OP_MASK,
		OP_DRAIN,
		OP_END
	} stim_op_e;

	typedef struct {
		stim_op_e   kind;
		bdda_in_t   item;
		logic [6:0] mask;
	} stim_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	bdda_in_t   req = '0;
	logic       done;
	bdda_out_t  rsp;
	logic       cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;

	stim_t       pending[$];
	bdda_out_t   exp_returns[$];
	logic [6:0]  weekend_off = MASK_RESET;
	int unsigned accept_cnt = 0;
	int unsigned issue_cnt = 0;
	int unsigned errors = 0;
	int unsigned gap_left = 0;
	int unsigned burst_left = 0;
	logic        holding = 1'b0;
	logic        stim_done = 1'b0;

	business_day_date_advance u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int unsigned days_in_month(int unsigned yr, int unsigned mo);
		logic leap;
		leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
		case (mo)
			2: return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic bdda_out_t calc_return_date(bdda_in_t it, logic [6:0] mask);
		int unsigned yr, mo, dy, cnt, wd, per_week, weeks, left, span, rest, a, yy, mm;
		bdda_out_t   r;
		yr = it.start_year;
		mo = it.start_month;
		dy = it.start_day;
		cnt = it.business_days;
		wd = 0;
		r.bad_date = 1'b0;
		if (mo < 1 || mo > 12 || dy < 1 || dy > days_in_month(yr, mo)) begin
			r.bad_date = 1'b1;
		end else begin
			// March-based weekday; the extra 400 years keep the year positive.
			a = (14 - mo) / 12;
			yy = yr + 400 - a;
			mm = mo + 12 * a - 2;
			wd = (dy + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
			per_week = 0;
			for (int i = 0; i < 7; i++)
				if (!mask[i])
					per_week++;
			if (cnt > 0 && per_week > 0) begin
				// Whole weeks first, then the partial week day by day.
				weeks = (cnt - 1) / per_week;
				left = cnt - weeks * per_week;
				span = 7 * weeks;
				for (int i = 0; i < 7; i++) begin
					if (!mask[(wd + i) % 7]) begin
						left--;
						if (left == 0) begin
							span += i + 1;
							break;
						end
					end
				end
				wd = (wd + span) % 7;
				rest = days_in_month(yr, mo) - dy;
				while (span > rest) begin
					span -= rest + 1;
					dy = 1;
					mo++;
					if (mo > 12) begin
						mo = 1;
						yr++;
					end
					rest = days_in_month(yr, mo) - dy;
				end
				dy += span;
			end
		end
		r.return_year = yr[13:0];
		r.return_month = mo[3:0];
		r.return_day = dy[4:0];
		r.return_weekday = wd[2:0];
		return r;
	endfunction

	function automatic bdda_in_t random_vacation(logic [6:0] mask);
		int unsigned p, yr, mo, dy;
		bdda_in_t    v;
		p = $urandom_range(0, 99);
		if (p < 70)
			yr = $urandom_range(1, 9999);
		else if (p < 82)
			yr = $urandom_range(0, 16383);
		else if (p < 87)
			yr = 0;
		else
			yr = $urandom_range(16370, 16383);
		if ($urandom_range(0, 99) < 92)
			mo = $urandom_range(1, 12);
		else
			mo = $urandom_range(0, 15);
		if ($urandom_range(0, 99) < 88)
			dy = $urandom_range(1, days_in_month(yr, mo));
		else
			dy = $urandom_range(0, 31);
		// Near the top of the year range, bias toward December so the year wraps.
		if (yr > 16380 && $urandom_range(0, 1) == 1) begin
			mo = 12;
			dy = $urandom_range(20, 31);
		end
		v.start_year = yr[13:0];
		v.start_month = mo[3:0];
		v.start_day = dy[4:0];
		p = $urandom_range(0, 99);
		if (mask == ALL_OFF)
			v.business_days = $urandom_range(0, 65535);
		else if (p < 80)
			v.business_days = $urandom_range(0, 40);
		else if (p < 97)
			v.business_days = $urandom_range(0, 400);
		else
			v.business_days = $urandom_range(0, 1000);
		return v;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		else if (p < 88)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 40);
	endfunction

	task automatic queue_vacation(int unsigned yr, int unsigned mo, int unsigned dy,
			int unsigned cnt);
		stim_t s;
		s.kind = OP_ITEM;
		s.item.start_year = yr[13:0];
		s.item.start_month = mo[3:0];
		s.item.start_day = dy[4:0];
		s.item.business_days = cnt[15:0];
		s.mask = '0;
		pending.push_back(s);
	endtask

	task automatic queue_op(stim_op_e kind, logic [6:0] mask);
		stim_t s;
		s.kind = kind;
		s.item = '0;
		s.mask = mask;
		pending.push_back(s);
	endtask

	// Driver: one transfer request at a time, updated at the falling edge.
	always @(negedge clk) begin : drive
		logic       nxt_start;
		logic       nxt_we;
		bdda_in_t   nxt_req;
		logic [6:0] nxt_wdata;
		logic       idle;
		nxt_start = 1'b0;
		nxt_we = 1'b0;
		nxt_req = req;
		nxt_wdata = cfg_wdata;
		if (arst_n) begin
			if (holding && accept_cnt == issue_cnt)
				holding = 1'b0;
			idle = (exp_returns.size() == 0) && !busy && !holding;
			if (holding) begin
				nxt_start = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (pending.size() > 0) begin
				case (pending[0].kind)
					OP_ITEM: begin
						nxt_req = pending[0].item;
						nxt_start = 1'b1;
						holding = 1'b1;
						issue_cnt++;
						void'(pending.pop_front());
						if (burst_left > 0) begin
							burst_left--;
							gap_left = 0;
						end else begin
							if ($urandom_range(0, 99) < 3)
								burst_left = $urandom_range(20, 60);
							gap_left = pick_gap();
						end
					end
					OP_MASK: begin
						if (idle) begin
							nxt_we = 1'b1;
							nxt_wdata = pending[0].mask;
							void'(pending.pop_front());
						end
					end
					OP_DRAIN: begin
						if (idle)
							void'(pending.pop_front());
					end
					OP_END: begin
						if (idle) begin
							void'(pending.pop_front());
							stim_done = 1'b1;
						end
					end
				endcase
			end
		end
		start <= nxt_start;
		req <= nxt_req;
		cfg_we <= nxt_we;
		cfg_wdata <= nxt_wdata;
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Monitor: tracks the mask, predicts each accepted transfer and checks each result.
	always @(posedge clk) begin : watch
		bdda_out_t want;
		if (!arst_n) begin
			weekend_off = MASK_RESET;
		end else begin
			if (cfg_we)
				weekend_off = cfg_wdata;
			if (start && !busy) begin
				exp_returns.push_back(calc_return_date(req, weekend_off));
				accept_cnt++;
			end
			if (done) begin
				if (exp_returns.size() == 0) begin
					errors++;
					$display("%0t: result with nothing pending, expected none, actual %p",
						$time, rsp);
				end else begin
					want = exp_returns.pop_front();
					check_field("return_year", want.return_year, rsp.return_year);
					check_field("return_month", want.return_month, rsp.return_month);
					check_field("return_day", want.return_day, rsp.return_day);
					check_field("return_weekday", want.return_weekday, rsp.return_weekday);
					check_field("bad_date", want.bad_date, rsp.bad_date);
				end
			end
		end
	end

	initial begin : timeout
		for (int n = 0; n < LIMIT; n++)
			@(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [6:0] m;
		// Directed part under the reset mask, Friday and Saturday off.
		queue_vacation(2024, 3, 15, 0);
		queue_vacation(2024, 3, 15, 1);
		queue_vacation(2024, 2, 29, 1);
		queue_vacation(2023, 2, 29, 3);
		queue_vacation(2024, 0, 10, 5);
		queue_vacation(2024, 13, 10, 5);
		queue_vacation(16383, 15, 31, 65535);
		queue_vacation(2024, 6, 0, 2);
		queue_vacation(2023, 4, 31, 2);
		queue_vacation(0, 2, 29, 10);
		queue_vacation(16383, 12, 31, 5);
		queue_vacation(16383, 1, 1, 1);
		queue_vacation(1, 1, 1, 1);
		queue_vacation(9999, 12, 31, 20);
		queue_vacation(1900, 2, 28, 2);
		queue_vacation(2000, 2, 28, 2);
		queue_vacation(2024, 1, 31, 30);
		queue_vacation(2024, 12, 20, 15);
		queue_vacation(2024, 6, 7, 65535);
		// With every weekday off, a nonzero count leaves the date where it is.
		queue_op(OP_MASK, ALL_OFF);
		queue_vacation(2024, 5, 5, 100);
		queue_vacation(2024, 5, 5, 0);
		queue_op(OP_MASK, NONE_OFF);
		queue_vacation(2024, 1, 1, 65535);
		queue_vacation(2024, 1, 1, 1);
		queue_op(OP_DRAIN, '0);

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: m = SAT_SUN;
				1: m = NONE_OFF;
				2: m = ALL_OFF;
				3: m = SAT_ONLY;
				4: m = SUN_ONLY;
				9: m = FRI_SAT;
				default: m = $urandom_range(0, 127);
			endcase
			queue_op(OP_MASK, m);
			for (int k = 0; k < 70; k++) begin
				pending.push_back('{OP_ITEM, random_vacation(m), '0});
				// Hold the sender off until everything in flight has come back.
				if (k == 35)
					queue_op(OP_DRAIN, '0);
			end
			queue_op(OP_DRAIN, '0);
		end
		queue_op(OP_END, '0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!stim_done)
			@(posedge clk);
		repeat (TAIL) @(negedge clk);
		if (errors == 0 && exp_returns.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
